@@ rtl/core/id_set_table_unit_macros.svh @@
// Assertion macros shared by the id set table RTL.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef ID_SET_TABLE_UNIT_MACROS_SVH
`define ID_SET_TABLE_UNIT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define IST_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("id set table: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define IST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("id set table: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define IST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("id set table: next-cycle check failed");

`endif

@@ rtl/core/ist_pkg.sv @@
// Shared types and constants of the id set table.
// No dependencies; used by ist_store and id_set_table_unit.
`default_nettype none

package ist_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = 5;
  localparam int IDENT_W  = 32;

  typedef logic signed [IDENT_W-1:0] ident_t;
  typedef logic [1:0]                kind_t;

  localparam kind_t KIND_ADD = 2'd0;
  localparam kind_t KIND_DEL = 2'd1;
  localparam kind_t KIND_HAS = 2'd2;

  localparam ident_t NO_IDENT = -32'sd1;

  // Request from the controller to the entry store.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ident_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/ist_store.sv @@
// Entry store of the id set table: one write and one registered read port.
// Depends on ist_pkg for the request struct and depth.
`default_nettype none

module ist_store (
  input  wire logic             clk,
  input  wire ist_pkg::mem_req_t req,
  output ist_pkg::ident_t        rd_data
);

  ist_pkg::ident_t mem [ist_pkg::CAPACITY];
  ist_pkg::ident_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/id_set_table_unit.sv @@
// Top level of the id set table: controller, fill count and result register.
// Depends on ist_pkg, ist_store and id_set_table_unit_macros.svh.
//
// Usage: each input beat (in_kind, in_ident) asks to add, delete or test one
// identifier; each gives exactly one result beat (out_status, out_found,
// out_count). Both channels use valid/stall; a beat moves when valid is high
// and stall is low. The block works on one item at a time: in_stall is high
// from the cycle after acceptance until the controller is idle again.
// Entries live in a single-port-read memory scanned one entry per cycle with
// reads pipelined back to back; a hit stops the scan early, while a miss
// scans every stored entry. A delete that hits then reads the last entry
// and writes it back into the freed slot before the response step.
// The result sits in an output register; the block takes a new item while it
// waits, and stalls only the response step if the previous result is still
// unread. Reset (synchronous, rst_n low) empties the set at once; memory
// contents are not cleared since only entries below the count are read.
`default_nettype none
`include "id_set_table_unit_macros.svh"

module id_set_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_kind,
  input  wire logic signed [31:0]            in_ident,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic                               out_found,
  output logic [ist_pkg::COUNT_W-1:0]        out_count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MVRD = 5'b00100,
    S_MVWR = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [ist_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [ist_pkg::CNT_W-1:0] issue_idx_r, issue_idx_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [ist_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [ist_pkg::IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  ist_pkg::kind_t            kind_r;
  ist_pkg::ident_t           key_r;
  logic                      res_status_r, res_status_nxt;
  logic                      res_found_r, res_found_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_status_r, out_found_r;
  logic [ist_pkg::COUNT_W-1:0] out_count_r;
  logic                      load_out;

  ist_pkg::mem_req_t mem_req;
  ist_pkg::ident_t   rd_data;

  logic in_acc;
  logic issuing;
  logic match;
  logic [ist_pkg::IDX_W-1:0] last_idx;

  ist_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issuing  = (issue_idx_r < fill_r);
  assign match    = cmp_vld_r && (rd_data == key_r);
  assign last_idx = ist_pkg::IDX_W'(fill_r - ist_pkg::CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    issue_idx_nxt  = issue_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_idx_nxt    = hit_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    load_out       = 1'b0;
    mem_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          issue_idx_nxt = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing && !match) begin
          // keep one read in flight per cycle
          mem_req.rd_en = 1'b1;
          mem_req.rd_addr = issue_idx_r[ist_pkg::IDX_W-1:0];
          issue_idx_nxt = issue_idx_r + ist_pkg::CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_idx_r[ist_pkg::IDX_W-1:0];
        end else begin
          res_found_nxt = 1'b0;
          res_status_nxt = 1'b1;
          state_nxt = S_RESP;
          case (kind_r)
            ist_pkg::KIND_ADD: begin
              if (key_r != ist_pkg::NO_IDENT && !match &&
                  fill_r < ist_pkg::CNT_W'(ist_pkg::CAPACITY)) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = fill_r[ist_pkg::IDX_W-1:0];
                mem_req.wr_data = key_r;
                fill_nxt        = fill_r + ist_pkg::CNT_W'(1);
                res_status_nxt  = 1'b0;
              end
            end
            ist_pkg::KIND_DEL: begin
              if (match) begin
                hit_idx_nxt    = cmp_idx_r;
                res_status_nxt = 1'b0;
                state_nxt      = S_MVRD;
              end
            end
            ist_pkg::KIND_HAS: begin
              if (key_r != ist_pkg::NO_IDENT) begin
                res_status_nxt = 1'b0;
                res_found_nxt  = match;
              end
            end
            default: begin
              res_status_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MVRD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = last_idx;
        state_nxt       = S_MVWR;
      end
      S_MVWR: begin
        // move the last entry into the freed slot
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = hit_idx_r;
        mem_req.wr_data = rd_data;
        fill_nxt        = fill_r - ist_pkg::CNT_W'(1);
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r  <= issue_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    if (in_acc) begin
      kind_r <= in_kind;
      key_r  <= in_ident;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_count_r  <= ist_pkg::COUNT_W'(fill_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

  `IST_ASSERT_ALWAYS(a_fill_bound, fill_r <= ist_pkg::CNT_W'(ist_pkg::CAPACITY))
  `IST_ASSERT_NEXT(a_accept_scans, in_acc, state_r == S_SCAN)
  `IST_ASSERT_SAME(a_scan_in_range, mem_req.rd_en && state_r == S_SCAN, issue_idx_r < fill_r)
  `IST_ASSERT_SAME(a_out_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP)

endmodule

`default_nettype wire
